>>> rtl/toc_pkg.sv
// ----------------------------------------------------------------------------
// toc_pkg: shared definitions for the tuple orbit canonicalizer
// Table sizes, register indexes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package toc_pkg;

	localparam int MaxDegree = 16;
	localparam int MaxGroup  = 256;
	localparam int PosW      = $clog2(MaxDegree);
	localparam int RowW      = $clog2(MaxGroup);
	localparam int AddrW     = PosW + RowW;
	localparam int DigitW    = 6;

	localparam logic [1:0] CFG_RADIX = 2'd0;
	localparam logic [1:0] CFG_WIDTH = 2'd1;
	localparam logic [1:0] CFG_GROUP = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_POW    = 10'b0000000010,
		ST_DIV    = 10'b0000000100,
		ST_ROWCLR = 10'b0000001000,
		ST_READ   = 10'b0000010000,
		ST_APPLY  = 10'b0000100000,
		ST_COMP   = 10'b0001000000,
		ST_CMP    = 10'b0010000000,
		ST_DONE   = 10'b0100000000,
		ST_SPARE  = 10'b1000000000
	} state_t;

endpackage

>>> rtl/toc_ram.sv
// ----------------------------------------------------------------------------
// toc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module toc_ram #(
	parameter int Width = 4,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/tuple_orbit_canonicalizer.sv
// ----------------------------------------------------------------------------
// tuple_orbit_canonicalizer: least image of a tuple code over a loaded group
// A load item writes one table entry. A code item is worked by the shared
// bit-serial divider and the one shared 64x7 multiplier. One item is worked at a time.
// Reset sets radix 2, width 1, group count 1; the table is unset until loaded.
// ----------------------------------------------------------------------------
module tuple_orbit_canonicalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  element,
	input  logic [3:0]  position,
	input  logic [3:0]  target,
	input  logic [63:0] code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] canonical_code,
	output logic        already_min,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	toc_pkg::state_t state_q;
	logic [6:0]  radix_q;
	logic [4:0]  width_q;
	logic [8:0]  groups_q;
	logic [6:0]  base;
	logic [4:0]  wid;
	logic [8:0]  grp;
	logic [63:0] code_q, s_q, rest_q, img_q, best_q;
	logic [4:0]  cnt_q;
	logic [5:0]  rem_q, bit_q;
	logic [3:0]  dig_q, i_q, j_q;
	logic [8:0]  g_q;
	logic [toc_pkg::DigitW-1:0] digits_q [toc_pkg::MaxDegree];
	logic [toc_pkg::DigitW-1:0] moved_q  [toc_pkg::MaxDegree];
	logic [63:0] res_code_q;
	logic        res_canon_q;
	logic [1:0]  res_stat_q;
	logic        out_valid_q;
	logic [63:0] out_code_q;
	logic        out_canon_q;
	logic [1:0]  out_stat_q;
	logic [63:0] mul_a;
	logic [70:0] prod;
	logic [6:0]  remn;
	logic        ge;
	logic [63:0] new_best;
	logic        wr_en, accept, out_free;
	logic [3:0]  rd_data;

	assign base = (radix_q < 7'd2) ? 7'd2 : ((radix_q > 7'd64) ? 7'd64 : radix_q);
	assign wid  = (width_q == 5'd0) ? 5'd1 : ((width_q > 5'd16) ? 5'd16 : width_q);
	assign grp  = (groups_q == 9'd0) ? 9'd1 : ((groups_q > 9'd256) ? 9'd256 : groups_q);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != toc_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign wr_en     = accept && !mode;
	assign out_free  = !out_valid_q || !out_stall;

	assign mul_a    = (state_q == toc_pkg::ST_POW) ? s_q : img_q;
	assign prod     = mul_a * base;
	assign remn     = {rem_q, rest_q[63]};
	assign ge       = (remn >= base);
	assign new_best = (img_q < best_q) ? img_q : best_q;

	toc_ram #(.Width(4), .Depth(toc_pkg::MaxGroup * toc_pkg::MaxDegree)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({element, position}),
		.wr_data (target),
		.rd_addr ({g_q[7:0], i_q}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= 7'd2;
			width_q  <= 5'd1;
			groups_q <= 9'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				toc_pkg::CFG_RADIX: radix_q  <= cfg_data[6:0];
				toc_pkg::CFG_WIDTH: width_q  <= cfg_data[4:0];
				toc_pkg::CFG_GROUP: groups_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= toc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != toc_pkg::ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				toc_pkg::ST_IDLE: begin
					if (accept && mode) begin
						code_q  <= code;
						s_q     <= 64'd1;
						cnt_q   <= 5'd0;
						state_q <= toc_pkg::ST_POW;
					end
				end
				toc_pkg::ST_POW: begin
					if (cnt_q == wid) begin
						if (code_q >= s_q) begin
							res_code_q  <= 64'd0;
							res_canon_q <= 1'b0;
							res_stat_q  <= toc_pkg::STAT_RANGE;
							state_q     <= toc_pkg::ST_DONE;
						end else begin
							rest_q  <= code_q;
							dig_q   <= 4'(wid - 5'd1);
							bit_q   <= 6'd0;
							rem_q   <= 6'd0;
							state_q <= toc_pkg::ST_DIV;
						end
					end else if (prod[70:64] != 7'd0) begin
						res_code_q  <= 64'd0;
						res_canon_q <= 1'b0;
						res_stat_q  <= toc_pkg::STAT_OVERFLOW;
						state_q     <= toc_pkg::ST_DONE;
					end else begin
						s_q   <= prod[63:0];
						cnt_q <= cnt_q + 5'd1;
					end
				end
				toc_pkg::ST_DIV: begin
					rest_q <= {rest_q[62:0], ge};
					bit_q  <= bit_q + 6'd1;
					if (bit_q == 6'd63) begin
						digits_q[dig_q] <= ge ? 6'(remn - base) : remn[5:0];
						rem_q <= 6'd0;
						if (dig_q == 4'd0) begin
							g_q     <= 9'd0;
							best_q  <= code_q;
							state_q <= toc_pkg::ST_ROWCLR;
						end else begin
							dig_q <= dig_q - 4'd1;
						end
					end else begin
						rem_q <= ge ? 6'(remn - base) : remn[5:0];
					end
				end
				toc_pkg::ST_ROWCLR: begin
					for (int k = 0; k < toc_pkg::MaxDegree; k++) begin
						moved_q[k] <= '0;
					end
					i_q     <= 4'd0;
					state_q <= toc_pkg::ST_READ;
				end
				toc_pkg::ST_READ: begin
					state_q <= toc_pkg::ST_APPLY;
				end
				toc_pkg::ST_APPLY: begin
					if ({1'b0, rd_data} < wid) begin
						moved_q[rd_data] <= digits_q[i_q];
					end
					if ({1'b0, i_q} == wid - 5'd1) begin
						j_q     <= 4'd0;
						img_q   <= 64'd0;
						state_q <= toc_pkg::ST_COMP;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= toc_pkg::ST_READ;
					end
				end
				toc_pkg::ST_COMP: begin
					img_q <= prod[63:0] + {58'd0, moved_q[j_q]};
					if ({1'b0, j_q} == wid - 5'd1) begin
						state_q <= toc_pkg::ST_CMP;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				toc_pkg::ST_CMP: begin
					best_q <= new_best;
					if (g_q == grp - 9'd1) begin
						res_code_q  <= new_best;
						res_canon_q <= (new_best == code_q);
						res_stat_q  <= toc_pkg::STAT_OK;
						state_q     <= toc_pkg::ST_DONE;
					end else begin
						g_q     <= g_q + 9'd1;
						state_q <= toc_pkg::ST_ROWCLR;
					end
				end
				toc_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_code_q  <= res_code_q;
						out_canon_q <= res_canon_q;
						out_stat_q  <= res_stat_q;
						state_q     <= toc_pkg::ST_IDLE;
					end
				end
				default: state_q <= toc_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign canonical_code = out_code_q;
	assign already_min    = out_canon_q;
	assign status         = out_stat_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != toc_pkg::STAT_OK) |-> (canonical_code == 64'd0) && !already_min)
		else $error("error result carries a nonzero code");

	a_pow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == toc_pkg::ST_POW) |-> (cnt_q <= wid))
		else $error("power count passed the tuple width");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == toc_pkg::ST_DONE) && out_free |=> out_valid && (state_q == toc_pkg::ST_IDLE))
		else $error("finished item was not presented");

endmodule

>>> dv/toc_checker.sv
// ----------------------------------------------------------------------------
// toc_checker: scoreboard for the tuple orbit canonicalizer
// Tracks the register settings and the permutation table from the accepted
// traffic, predicts the least image of each accepted code item and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module toc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  element,
	input  logic [3:0]  position,
	input  logic [3:0]  target,
	input  logic [63:0] code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] canonical_code,
	input  logic        already_min,
	input  logic [1:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] canon;
		logic        least;
		logic [1:0]  stat;
	} orbit_result_t;

	logic [6:0] radix_reg;
	logic [4:0] width_reg;
	logic [8:0] group_reg;
	logic [3:0] perm_rows [toc_pkg::MaxGroup][toc_pkg::MaxDegree];
	orbit_result_t orbit_expected [$];

	function automatic orbit_result_t least_image(input logic [63:0] c);
		orbit_result_t res;
		longint unsigned base, wid, rows, space, rest, best, img;
		logic [5:0] digits [toc_pkg::MaxDegree];
		logic [5:0] moved [toc_pkg::MaxDegree];
		bit fits;
		res = '0;
		base = (radix_reg < 2) ? 2 : (radix_reg > 64) ? 64 : radix_reg;
		wid = (width_reg < 1) ? 1 :
			(width_reg > toc_pkg::MaxDegree) ? toc_pkg::MaxDegree : width_reg;
		rows = (group_reg < 1) ? 1 :
			(group_reg > toc_pkg::MaxGroup) ? toc_pkg::MaxGroup : group_reg;
		space = 1;
		fits = 1'b1;
		for (int i = 0; i < wid; i++) begin
			if (space > 64'hFFFF_FFFF_FFFF_FFFF / base) fits = 1'b0;
			else space = space * base;
		end
		if (!fits) begin
			res.stat = toc_pkg::STAT_OVERFLOW;
			return res;
		end
		if (c >= space) begin
			res.stat = toc_pkg::STAT_RANGE;
			return res;
		end
		rest = c;
		for (int i = int'(wid) - 1; i >= 0; i--) begin
			digits[i] = 6'(rest % base);
			rest = rest / base;
		end
		best = c;
		for (int g = 0; g < rows; g++) begin
			for (int i = 0; i < toc_pkg::MaxDegree; i++) moved[i] = '0;
			for (int i = 0; i < wid; i++)
				if (perm_rows[g][i] < wid) moved[perm_rows[g][i]] = digits[i];
			img = 0;
			for (int i = 0; i < wid; i++) img = img * base + moved[i];
			if (img < best) best = img;
		end
		res.canon = best;
		res.least = (best == c);
		res.stat = toc_pkg::STAT_OK;
		return res;
	endfunction

	assign pending = orbit_expected.size();

	always @(posedge clk or negedge arst_n) begin
		orbit_result_t exp_res;
		if (!arst_n) begin
			radix_reg = 7'd2;
			width_reg = 5'd1;
			group_reg = 9'd1;
			errors = 0;
			orbit_expected.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					toc_pkg::CFG_RADIX: radix_reg = cfg_data[6:0];
					toc_pkg::CFG_WIDTH: width_reg = cfg_data[4:0];
					toc_pkg::CFG_GROUP: group_reg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (orbit_expected.size() == 0) begin
					$error("result item with no expectation: code %h", canonical_code);
					errors++;
				end else begin
					exp_res = orbit_expected.pop_front();
					if (canonical_code !== exp_res.canon) begin
						$error("canonical_code expected %h got %h",
							exp_res.canon, canonical_code);
						errors++;
					end
					if (already_min !== exp_res.least) begin
						$error("already_min expected %b got %b",
							exp_res.least, already_min);
						errors++;
					end
					if (status !== exp_res.stat) begin
						$error("status expected %0d got %0d", exp_res.stat, status);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (mode) orbit_expected.push_back(least_image(code));
				else perm_rows[element][position] = target;
			end
		end
	end
endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the tuple orbit canonicalizer
// Drives directed and random phases; a random one sets the registers while
// the block is idle, loads every table entry in use, then sends code items
// with random gaps as the output stalls at random. A checker scores them.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [7:0]  element = '0;
	logic [3:0]  position = '0;
	logic [3:0]  target = '0;
	logic [63:0] code = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] canonical_code;
	logic        already_min;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	int          errors;
	int          pending;
	int          item_count = 0;
	bit          no_gaps = 1'b0;

	tuple_orbit_canonicalizer uut (.*);
	toc_checker checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int len;
		forever begin
			@(posedge clk);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			out_stall <= ($urandom_range(0, 2) == 0);
			repeat (len - 1) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic m, input logic [7:0] el, input logic [3:0] pos,
			input logic [3:0] tgt, input logic [63:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		element <= el;
		position <= pos;
		target <= tgt;
		code <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		item_count++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_code(input logic [63:0] c);
		send_item(1'b1, 8'($urandom), 4'($urandom), 4'($urandom), c);
	endtask

	task automatic send_load(input int row, input int pos, input int tgt);
		send_item(1'b0, 8'(row), 4'(pos), 4'(tgt), {$urandom, $urandom});
	endtask

	// Sets the registers, loads every entry in use, then sends code items.
	task automatic run_phase(input int rad_raw, input int wid_raw, input int grp_raw,
			input int n_codes);
		int base, wid, rows, perm[16], tmp, j, sel;
		longint unsigned space, c;
		bit fits;
		settle();
		write_reg(toc_pkg::CFG_RADIX, 9'(rad_raw));
		write_reg(toc_pkg::CFG_WIDTH, 9'(wid_raw));
		write_reg(toc_pkg::CFG_GROUP, 9'(grp_raw));
		no_gaps = ($urandom_range(0, 3) == 0);
		base = rad_raw[6:0] < 2 ? 2 : rad_raw[6:0] > 64 ? 64 : rad_raw[6:0];
		wid = wid_raw[4:0] < 1 ? 1 : wid_raw[4:0] > 16 ? 16 : wid_raw[4:0];
		rows = grp_raw[8:0] < 1 ? 1 : grp_raw[8:0] > 256 ? 256 : grp_raw[8:0];
		space = 1;
		fits = 1'b1;
		for (int i = 0; i < wid; i++) begin
			if (space > 64'hFFFF_FFFF_FFFF_FFFF / base) fits = 1'b0;
			else space = space * base;
		end
		for (int g = 0; g < rows; g++) begin
			for (int i = 0; i < 16; i++) perm[i] = i;
			for (int i = wid - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			sel = $urandom_range(0, 3);
			for (int i = 0; i < wid; i++)
				send_load(g, i, sel == 0 ? $urandom_range(0, 15) : perm[i]);
		end
		for (int n = 0; n < n_codes; n++) begin
			if ($urandom_range(0, 15) == 0) begin
				if (rows < 256) send_load($urandom_range(rows, 255), $urandom, $urandom);
				else if (wid < 16) send_load($urandom, $urandom_range(wid, 15), $urandom);
			end
			sel = $urandom_range(0, 9);
			if (!fits || sel == 3) c = {$urandom, $urandom};
			else if (sel == 0) c = 0;
			else if (sel == 1) c = space - 1;
			else if (sel == 2) c = space + $urandom_range(0, 3);
			else begin
				c = 0;
				for (int i = 0; i < wid; i++)
					c = c * base + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, base - 1));
			end
			send_code(c);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: one digit of base two, one row.
		send_load(0, 0, 0);
		send_code(64'd0);
		send_code(64'd1);
		send_code(64'd2);
		send_code(64'hFFFF_FFFF_FFFF_FFFF);

		// Overflowing code space, at the limits and clamped from above.
		settle();
		write_reg(toc_pkg::CFG_RADIX, 9'd64);
		write_reg(toc_pkg::CFG_WIDTH, 9'd16);
		send_code(64'd0);
		send_code(64'd5);
		settle();
		write_reg(toc_pkg::CFG_RADIX, 9'h7F);
		write_reg(toc_pkg::CFG_WIDTH, 9'h1F);
		write_reg(toc_pkg::CFG_GROUP, 9'd0);
		send_code(64'd1);

		// Base three, three digits: a reversal, then a row that drops a digit
		// and sends two digits to the same place.
		settle();
		write_reg(toc_pkg::CFG_RADIX, 9'd3);
		write_reg(toc_pkg::CFG_WIDTH, 9'd3);
		write_reg(toc_pkg::CFG_GROUP, 9'd2);
		send_load(0, 0, 2);
		send_load(0, 1, 1);
		send_load(0, 2, 0);
		send_load(1, 0, 15);
		send_load(1, 1, 0);
		send_load(1, 2, 0);
		send_code(64'd0);
		send_code(64'd26);
		send_code(64'd27);
		send_code(64'd5);
		send_code(64'd15);

		run_phase(64, 1, 256, 12);
		run_phase(2, 1, 511, 8);
		run_phase(0, 16, 3, 10);
		run_phase(15, 16, 2, 8);
		run_phase(16, 16, 1, 4);
		run_phase(1, 0, 1, 10);
		while (item_count < 1170) begin
			if ($urandom_range(0, 5) == 0)
				run_phase($urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 9), 20);
			else
				run_phase($urandom_range(2, 10), $urandom_range(1, 6), $urandom_range(1, 8),
					$urandom_range(20, 40));
		end

		settle();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
